[src/imu_frame_parser_assert.svh]
// ----------------------------------------------------------------------------
// IMU frame parser assertion macros
// Concurrent assertion shorthands clocked on i_clk and disabled while
// i_rst_n is low. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_ASSERT_SVH
`define IMU_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define IFP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ifp: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define IFP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ifp: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define IFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ifp: next-cycle implication violated");

`else

`define IFP_ASSERT_ALWAYS(lbl, cond)
`define IFP_ASSERT_SAME(lbl, ante, cons)
`define IFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/ifp_pkg.sv]
// ----------------------------------------------------------------------------
// IMU frame parser package
// Shared widths, reset values, scaling constants, register indexes and the
// frame record passed from the byte collector to the decoder.
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int AXIS_W = 28;
    localparam int TEMP_W = 25;

    // Position of the checksum byte, the last of a frame.
    localparam logic [3:0] FRAME_LAST  = 4'd10;
    localparam int         STORE_DEPTH = 9;

    localparam logic [7:0] HEADER_RESET = 8'h55;
    localparam logic [7:0] RATE_RESET   = 8'h52;
    localparam logic [7:0] ANGLE_RESET  = 8'h53;

    // 2000/32768 and 180/32768 in Q16.16 are exact integer factors.
    localparam logic [11:0] RATE_SCALE  = 12'd4000;
    localparam logic [11:0] ANGLE_SCALE = 12'd360;

    // Temperature: round(t * 16384 / 85) = 192*|t| + floor((128*|t| + 85) / 170),
    // the division done as a multiplication by ceil(2^31 / 170).
    localparam logic [22:0]        ROUND_BIAS      = 23'd85;
    localparam logic [23:0]        RECIP_170       = 24'd12632257;
    localparam int                 RECIP_SHIFT     = 31;
    localparam logic signed [24:0] TEMP_OFFSET_Q16 = 25'sd2375680;

    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    typedef enum logic [1:0] {
        CFG_HEADER = 2'd0,
        CFG_RATE   = 2'd1,
        CFG_ANGLE  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]         frame_type;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] temp_raw;
    } t_frame;

endpackage

[src/ifp_channels_if.sv]
// ----------------------------------------------------------------------------
// IMU frame parser channels
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface ifp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifp_result_if;
    logic                             valid;
    logic                             ready;
    logic                             frame_kind;
    logic signed [ifp_pkg::AXIS_W-1:0] axis_x;
    logic signed [ifp_pkg::AXIS_W-1:0] axis_y;
    logic signed [ifp_pkg::AXIS_W-1:0] axis_z;
    logic signed [ifp_pkg::TEMP_W-1:0] temperature;
    logic                             temperature_valid;

    modport source (output valid, output frame_kind, output axis_x, output axis_y,
                    output axis_z, output temperature, output temperature_valid,
                    input ready);
    modport sink   (input valid, input frame_kind, input axis_x, input axis_y,
                    input axis_z, input temperature, input temperature_valid,
                    output ready);
endinterface

[src/ifp_collector.sv]
// ----------------------------------------------------------------------------
// IMU frame parser byte collector
// Hunts for the header byte, stores the nine payload bytes of a frame and,
// on the checksum byte, places the assembled frame in the frame register.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_assert.svh"

module ifp_collector (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ifp_byte_if.sink        i_rx,
    input  logic [7:0]      i_header,
    output logic            o_frm_valid,
    input  logic            i_frm_ready,
    output ifp_pkg::t_frame o_frame
);

    logic [3:0]      r_pos;
    logic [3:0]      n_pos;
    logic [7:0]      r_store [ifp_pkg::STORE_DEPTH];
    logic            r_frm_valid;
    ifp_pkg::t_frame r_frame;
    logic            w_accept;
    logic            w_last;

    assign i_rx.ready = !r_frm_valid || i_frm_ready;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_last     = (r_pos == ifp_pkg::FRAME_LAST);

    always_comb begin
        n_pos = r_pos;
        if (r_pos == 4'd0) begin
            if (i_rx.rx_byte == i_header) begin
                n_pos = 4'd1;
            end
        end else if (w_last) begin
            n_pos = 4'd0;
        end else begin
            n_pos = r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 4'd0;
            r_frm_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pos <= n_pos;
            end
            if (w_accept && w_last) begin
                r_frm_valid <= 1'b1;
            end else if (i_frm_ready) begin
                r_frm_valid <= 1'b0;
            end
        end
    end

    // Payload store: byte position p lands in entry p-1.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ifp_pkg::STORE_DEPTH; i++) begin
            if (w_accept && r_pos == 4'(i + 1)) begin
                r_store[i] <= i_rx.rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_frame.frame_type <= r_store[0];
            r_frame.x          <= {r_store[2], r_store[1]};
            r_frame.y          <= {r_store[4], r_store[3]};
            r_frame.z          <= {r_store[6], r_store[5]};
            r_frame.temp_raw   <= {r_store[8], r_store[7]};
        end
    end

    assign o_frm_valid = r_frm_valid;
    assign o_frame     = r_frame;

    `IFP_ASSERT_ALWAYS(a_pos_range, r_pos <= ifp_pkg::FRAME_LAST)
    `IFP_ASSERT_NEXT(a_frame_done, w_accept && w_last, r_frm_valid && r_pos == 4'd0)
    `IFP_ASSERT_NEXT(a_frame_held, r_frm_valid && !i_frm_ready, r_frm_valid)

endmodule

[src/ifp_decoder.sv]
// ----------------------------------------------------------------------------
// IMU frame parser decoder
// Matches the frame type against the configured codes, scales the three axes
// and the temperature to Q16.16 and holds the item in the result register.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_assert.svh"

module ifp_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_rate_type,
    input  logic [7:0]      i_angle_type,
    input  logic            i_frm_valid,
    output logic            o_frm_ready,
    input  ifp_pkg::t_frame i_frame,
    ifp_result_if.source    o_res
);

    logic                             r_valid;
    logic                             r_kind;
    logic signed [ifp_pkg::AXIS_W-1:0] r_axis_x;
    logic signed [ifp_pkg::AXIS_W-1:0] r_axis_y;
    logic signed [ifp_pkg::AXIS_W-1:0] r_axis_z;
    logic signed [ifp_pkg::TEMP_W-1:0] r_temp;
    logic                             r_temp_valid;

    logic                             w_can_load;
    logic                             w_is_rate;
    logic                             w_is_angle;
    logic [11:0]                      w_scale;
    logic signed [ifp_pkg::AXIS_W-1:0] w_scale_s;
    logic signed [ifp_pkg::AXIS_W-1:0] w_axis_x;
    logic signed [ifp_pkg::AXIS_W-1:0] w_axis_y;
    logic signed [ifp_pkg::AXIS_W-1:0] w_axis_z;
    logic [15:0]                      w_mag;
    logic [22:0]                      w_num;
    logic [46:0]                      w_prod;
    logic [15:0]                      w_frac;
    logic [22:0]                      w_base;
    logic [22:0]                      w_mag_q;
    logic signed [ifp_pkg::TEMP_W-1:0] w_tq;
    logic signed [ifp_pkg::TEMP_W-1:0] w_temp;

    assign w_can_load  = !r_valid || o_res.ready;
    assign o_frm_ready = w_can_load;

    // Equal type codes decode as a rate frame.
    assign w_is_rate  = (i_frame.frame_type == i_rate_type);
    assign w_is_angle = !w_is_rate && (i_frame.frame_type == i_angle_type);

    assign w_scale   = w_is_rate ? ifp_pkg::RATE_SCALE : ifp_pkg::ANGLE_SCALE;
    assign w_scale_s = $signed({16'd0, w_scale});
    assign w_axis_x  = ifp_pkg::AXIS_W'(i_frame.x) * w_scale_s;
    assign w_axis_y  = ifp_pkg::AXIS_W'(i_frame.y) * w_scale_s;
    assign w_axis_z  = ifp_pkg::AXIS_W'(i_frame.z) * w_scale_s;

    // Rounded temperature, worked on the magnitude and the sign put back.
    assign w_mag   = i_frame.temp_raw[15] ? 16'(-i_frame.temp_raw) : 16'(i_frame.temp_raw);
    assign w_num   = {w_mag, 7'd0} + ifp_pkg::ROUND_BIAS;
    assign w_prod  = 47'(w_num) * 47'(ifp_pkg::RECIP_170);
    assign w_frac  = w_prod[ifp_pkg::RECIP_SHIFT +: 16];
    assign w_base  = {w_mag, 7'd0} + {1'b0, w_mag, 6'd0};
    assign w_mag_q = w_base + 23'(w_frac);
    assign w_tq    = $signed(ifp_pkg::TEMP_W'(w_mag_q));
    assign w_temp  = ifp_pkg::TEMP_OFFSET_Q16 + (i_frame.temp_raw[15] ? -w_tq : w_tq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_can_load) begin
            r_valid <= i_frm_valid && (w_is_rate || w_is_angle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_load && i_frm_valid) begin
            r_kind       <= w_is_rate ? ifp_pkg::KIND_RATE : ifp_pkg::KIND_ANGLE;
            r_axis_x     <= w_axis_x;
            r_axis_y     <= w_axis_y;
            r_axis_z     <= w_axis_z;
            r_temp       <= w_is_rate ? '0 : w_temp;
            r_temp_valid <= !w_is_rate;
        end
    end

    assign o_res.valid             = r_valid;
    assign o_res.frame_kind        = r_kind;
    assign o_res.axis_x            = r_axis_x;
    assign o_res.axis_y            = r_axis_y;
    assign o_res.axis_z            = r_axis_z;
    assign o_res.temperature       = r_temp;
    assign o_res.temperature_valid = r_temp_valid;

    `IFP_ASSERT_SAME(a_kind_temp, r_valid, r_temp_valid == (r_kind == ifp_pkg::KIND_ANGLE))
    `IFP_ASSERT_SAME(a_rate_no_temp, r_valid && r_kind == ifp_pkg::KIND_RATE, r_temp == '0)
    `IFP_ASSERT_NEXT(a_unknown_drop, i_frm_valid && w_can_load && !w_is_rate && !w_is_angle, !r_valid)

endmodule

[src/imu_frame_parser.sv]
// ----------------------------------------------------------------------------
// IMU frame parser
// Parses 11-byte serial IMU frames into angular rate or angle and
// temperature results in signed Q16.16.
//
//   channel   direction  payload                                   handshake
//   i_rx      in         rx_byte                                   valid/ready
//   o_res     out        frame_kind, axis_x/y/z, temperature(+vld) valid/ready
//   i_cfg_*   in         index, data                               write enable
//
// One byte is accepted per cycle while i_rx is not stalled. A frame moves from
// its checksum byte into the frame register and, via the decoder's multipliers,
// into the result register. Synchronous reset clears the frame position and
// the valid flags and loads the default header and type codes. A stall on
// o_res backs up through the frame register to i_rx only when a finished
// frame is still waiting; otherwise header hunting and byte collection carry on.
// ----------------------------------------------------------------------------
module imu_frame_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ifp_byte_if.sink      i_rx,
    ifp_result_if.source  o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);

    logic [7:0]      r_header;
    logic [7:0]      r_rate_type;
    logic [7:0]      r_angle_type;
    logic            w_frm_valid;
    logic            w_frm_ready;
    ifp_pkg::t_frame w_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header     <= ifp_pkg::HEADER_RESET;
            r_rate_type  <= ifp_pkg::RATE_RESET;
            r_angle_type <= ifp_pkg::ANGLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ifp_pkg::CFG_HEADER: begin
                    r_header <= i_cfg_data;
                end
                ifp_pkg::CFG_RATE: begin
                    r_rate_type <= i_cfg_data;
                end
                ifp_pkg::CFG_ANGLE: begin
                    r_angle_type <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    ifp_collector u_collector (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_header    (r_header),
        .o_frm_valid (w_frm_valid),
        .i_frm_ready (w_frm_ready),
        .o_frame     (w_frame)
    );

    ifp_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rate_type  (r_rate_type),
        .i_angle_type (r_angle_type),
        .i_frm_valid  (w_frm_valid),
        .o_frm_ready  (w_frm_ready),
        .i_frame      (w_frame),
        .o_res        (o_res)
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// IMU frame parser testbench
// Drives received bytes into the parser and checks every decoded result
// against a behavioural predictor of the frame collector and decoder. A
// directed part covers word and temperature extremes, unknown and shared
// type codes, header values inside a frame and register writes mid-frame.
// Random frames and noise then run under three idling patterns, one of them
// with a long receiver hold-off that fills the parser and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         HALF_PERIOD   = 6;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         RANDOM_BYTES  = 680;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         FRAME_BYTES   = 11;
    // Index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] CFG_SPARE     = 2'd3;

    typedef struct packed {
        logic                             frame_kind;
        logic signed [ifp_pkg::AXIS_W-1:0] axis_x;
        logic signed [ifp_pkg::AXIS_W-1:0] axis_y;
        logic signed [ifp_pkg::AXIS_W-1:0] axis_z;
        logic signed [ifp_pkg::TEMP_W-1:0] temperature;
        logic                             temperature_valid;
    } t_imu_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    ifp_byte_if   rx_if ();
    ifp_result_if res_if ();

    imu_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state: register copies, frame position and collected bytes.
    logic [7:0]  hdr_reg;
    logic [7:0]  rate_reg;
    logic [7:0]  angle_reg;
    logic [3:0]  frame_pos;
    logic [7:0]  frame_store [ifp_pkg::STORE_DEPTH];
    t_imu_result expected_frames [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_off_cycles;
    int fail_count;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [ifp_pkg::TEMP_W-1:0] temp_to_q16(
        input logic signed [15:0] raw
    );
        longint num;
        longint q;
        num = longint'(raw) * 16384;
        // Round half away from zero; t * 16384 / 85 never lands on a half.
        if (num >= 0)
            q = (num * 2 + 85) / 170;
        else
            q = -(((-num) * 2 + 85) / 170);
        return ifp_pkg::TEMP_W'(q + longint'(ifp_pkg::TEMP_OFFSET_Q16));
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0]         ftype;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] t;
        t_imu_result        r;
        if (frame_pos == 4'd0) begin
            if (b == hdr_reg)
                frame_pos = 4'd1;
        end else if (frame_pos < ifp_pkg::FRAME_LAST) begin
            frame_store[frame_pos - 4'd1] = b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            // Checksum byte: accepted unchecked, the frame is decoded now.
            frame_pos = 4'd0;
            ftype = frame_store[0];
            x = {frame_store[2], frame_store[1]};
            y = {frame_store[4], frame_store[3]};
            z = {frame_store[6], frame_store[5]};
            t = {frame_store[8], frame_store[7]};
            r = '0;
            if (ftype == rate_reg) begin
                r.frame_kind = ifp_pkg::KIND_RATE;
                r.axis_x = ifp_pkg::AXIS_W'(longint'(x) * longint'(ifp_pkg::RATE_SCALE));
                r.axis_y = ifp_pkg::AXIS_W'(longint'(y) * longint'(ifp_pkg::RATE_SCALE));
                r.axis_z = ifp_pkg::AXIS_W'(longint'(z) * longint'(ifp_pkg::RATE_SCALE));
                expected_frames.push_back(r);
            end else if (ftype == angle_reg) begin
                r.frame_kind = ifp_pkg::KIND_ANGLE;
                r.axis_x = ifp_pkg::AXIS_W'(longint'(x) * longint'(ifp_pkg::ANGLE_SCALE));
                r.axis_y = ifp_pkg::AXIS_W'(longint'(y) * longint'(ifp_pkg::ANGLE_SCALE));
                r.axis_z = ifp_pkg::AXIS_W'(longint'(z) * longint'(ifp_pkg::ANGLE_SCALE));
                r.temperature = temp_to_q16(t);
                r.temperature_valid = 1'b1;
                expected_frames.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            fail_count++;
        end
    endtask

    // Result checker: each accepted item is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_imu_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d x %0d",
                         $realtime, res_if.frame_kind, res_if.axis_x);
                fail_count++;
            end else begin
                want = expected_frames.pop_front();
                check_field("frame_kind", want.frame_kind, res_if.frame_kind);
                check_field("axis_x", want.axis_x, res_if.axis_x);
                check_field("axis_y", want.axis_y, res_if.axis_y);
                check_field("axis_z", want.axis_z, res_if.axis_z);
                check_field("temperature", want.temperature, res_if.temperature);
                check_field("temperature_valid", want.temperature_valid,
                            res_if.temperature_valid);
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready)
            @(posedge i_clk);
        decode_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z,
                              input logic [15:0] t, input logic [7:0] chk);
        send_byte(hdr_reg);
        send_byte(ftype);
        send_byte(x[7:0]);
        send_byte(x[15:8]);
        send_byte(y[7:0]);
        send_byte(y[15:8]);
        send_byte(z[7:0]);
        send_byte(z[15:8]);
        send_byte(t[7:0]);
        send_byte(t[15:8]);
        send_byte(chk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        // A frame of unknown type may still be in flight with nothing to show.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            ifp_pkg::CFG_HEADER: hdr_reg   = value;
            ifp_pkg::CFG_RATE:   rate_reg  = value;
            ifp_pkg::CFG_ANGLE:  angle_reg = value;
            default:             ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] random_word();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly whole frames with random content, the rest truncated frames and noise.
    task automatic run_random_frames(input int n_bytes);
        int         sent;
        int         pick;
        int         len;
        logic [7:0] ftype;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                case ($urandom_range(4))
                    0, 1:    ftype = rate_reg;
                    2, 3:    ftype = angle_reg;
                    default: ftype = 8'($urandom);
                endcase
                send_frame(ftype, random_word(), random_word(), random_word(),
                           random_word(), 8'($urandom));
                sent += FRAME_BYTES;
            end else if (pick < 90) begin
                // A cut-short frame swallows whatever bytes follow it.
                send_byte(hdr_reg);
                len = $urandom_range(1, 9);
                repeat (len) send_byte(8'($urandom));
                sent += len + 1;
            end else begin
                send_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_rate_extremes();
        // Non-header bytes while hunting are dropped; header values inside
        // the frame are plain data.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(rate_reg, 16'h8000, 16'h7FFF, 16'h5555, 16'h8000, 8'h55);
        wait_idle();
    endtask

    task automatic test_angle_extremes();
        send_frame(angle_reg, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 8'hFF);
        wait_idle();
    endtask

    task automatic test_unknown_type();
        send_frame(8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'h0100, 8'h00);
        send_frame(angle_reg, 16'h0000, 16'h0001, 16'hFFFE, 16'h0000, 8'h12);
        wait_idle();
    endtask

    task automatic test_equal_types_mid_frame();
        send_byte(hdr_reg);
        send_byte(angle_reg);
        send_byte(8'h34);
        send_byte(8'h12);
        wait_idle();
        // Both writes land while the frame is half collected.
        cfg_write(ifp_pkg::CFG_RATE, angle_reg);
        cfg_write(CFG_SPARE, 8'hA5);
        send_byte(8'hCC);
        send_byte(8'hED);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h3C);
        wait_idle();
    endtask

    task automatic test_random_receiver_slow();
        cfg_write(ifp_pkg::CFG_HEADER, 8'h00);
        cfg_write(ifp_pkg::CFG_RATE, 8'hFF);
        cfg_write(ifp_pkg::CFG_ANGLE, 8'h00);
        tx_idle_pct = 27;
        rx_idle_pct = 88;
        run_random_frames(RANDOM_BYTES);
        wait_idle();
    endtask

    task automatic test_random_sender_slow();
        cfg_write(ifp_pkg::CFG_HEADER, 8'hFF);
        cfg_write(ifp_pkg::CFG_RATE, 8'h00);
        cfg_write(ifp_pkg::CFG_ANGLE, 8'hFF);
        tx_idle_pct = 88;
        rx_idle_pct = 27;
        run_random_frames(RANDOM_BYTES);
        wait_idle();
    endtask

    task automatic test_random_backpressure();
        cfg_write(ifp_pkg::CFG_HEADER, 8'($urandom));
        cfg_write(ifp_pkg::CFG_RATE, 8'($urandom));
        cfg_write(ifp_pkg::CFG_ANGLE, 8'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off_cycles = HOLD_CYCLES;
        run_random_frames(RANDOM_BYTES);
        wait_idle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = ifp_pkg::CFG_HEADER;
        cfg_data        = 8'h00;
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = 8'h00;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        hold_off_cycles = 0;
        fail_count      = 0;
        cycle_count     = 0;
        hdr_reg         = ifp_pkg::HEADER_RESET;
        rate_reg        = ifp_pkg::RATE_RESET;
        angle_reg       = ifp_pkg::ANGLE_RESET;
        frame_pos       = 4'd0;
        foreach (frame_store[i])
            frame_store[i] = 8'h00;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_rate_extremes();
        test_angle_extremes();
        test_unknown_type();
        test_equal_types_mid_frame();
        test_random_receiver_slow();
        test_random_sender_slow();
        test_random_backpressure();

        if (fail_count == 0 && expected_frames.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
